// ===== src/fpas_pkg.sv =====
// Package: shared types and constants for the fp32 adder/subtractor.
package fpas_pkg;

    localparam logic [31:0] QUIET_NAN = 32'h7FC0_0000;
    localparam logic [7:0]  EXP_MAX   = 8'hFF;

    // Stage 1 -> stage 2: classified, ordered operands.
    typedef struct packed {
        logic        special;
        logic [31:0] special_bits;
        logic        sign;
        logic        eff_sub;
        logic [7:0]  big_e;
        logic [23:0] big_m;
        logic [23:0] small_m;
        logic [7:0]  shift;
    } t_s1;

    // Stage 2 -> stage 3: raw significand sum.
    typedef struct packed {
        logic        special;
        logic [31:0] special_bits;
        logic        sign;
        logic [7:0]  big_e;
        logic [24:0] sum;
    } t_s2;

    // Stage 3 -> output: packed result.
    typedef struct packed {
        logic [31:0] bits;
        logic        ovf;
    } t_s3;

endpackage

// ===== src/fpas_unpack.sv =====
// Module: operand unpack, special-case detection and magnitude ordering.
module fpas_unpack (
    input  logic               i_sub,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output fpas_pkg::t_s1      o_s1
);
    logic [31:0] b, big, sml;
    logic        a_nan, b_nan, a_inf, b_inf, a_ge;
    logic [7:0]  be, se;

    always_comb begin
        b     = i_b ^ {i_sub, 31'd0};
        a_nan = (i_a[30:23] == fpas_pkg::EXP_MAX) && (i_a[22:0] != '0);
        b_nan = (b[30:23] == fpas_pkg::EXP_MAX) && (b[22:0] != '0);
        a_inf = (i_a[30:23] == fpas_pkg::EXP_MAX) && (i_a[22:0] == '0);
        b_inf = (b[30:23] == fpas_pkg::EXP_MAX) && (b[22:0] == '0);
        a_ge  = i_a[30:0] >= b[30:0];
        big   = a_ge ? i_a : b;
        sml   = a_ge ? b : i_a;
        be    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        se    = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];

        o_s1.special      = a_nan | b_nan | a_inf | b_inf;
        if (a_nan || b_nan)
            o_s1.special_bits = fpas_pkg::QUIET_NAN;
        else if (a_inf && b_inf)
            o_s1.special_bits = (i_a[31] ^ b[31]) ? fpas_pkg::QUIET_NAN : i_a;
        else if (a_inf)
            o_s1.special_bits = i_a;
        else
            o_s1.special_bits = b;
        o_s1.sign    = big[31];
        o_s1.eff_sub = i_a[31] ^ b[31];
        o_s1.big_e   = be;
        o_s1.big_m   = {big[30:23] != 8'd0, big[22:0]};
        o_s1.small_m = {sml[30:23] != 8'd0, sml[22:0]};
        o_s1.shift   = be - se;
    end
endmodule

// ===== src/fpas_align_add.sv =====
// Module: alignment shift and significand add/subtract.
module fpas_align_add (
    input  fpas_pkg::t_s1 i_s1,
    output fpas_pkg::t_s2 o_s2
);
    logic [23:0] sm;

    always_comb begin
        sm = (i_s1.shift >= 8'd25) ? 24'd0 : (i_s1.small_m >> i_s1.shift[4:0]);
        o_s2.special      = i_s1.special;
        o_s2.special_bits = i_s1.special_bits;
        o_s2.sign         = i_s1.sign;
        o_s2.big_e        = i_s1.big_e;
        o_s2.sum          = i_s1.eff_sub ? ({1'b0, i_s1.big_m} - {1'b0, sm})
                                         : ({1'b0, i_s1.big_m} + {1'b0, sm});
    end
endmodule

// ===== src/fpas_norm.sv =====
// Module: normalization, subnormal/overflow handling and result packing.
module fpas_norm (
    input  fpas_pkg::t_s2 i_s2,
    output fpas_pkg::t_s3 o_s3
);
    logic [4:0]  lz;
    logic [4:0]  sh;
    logic [23:0] m;
    logic [8:0]  e;
    logic        found;

    always_comb begin
        // leading-zero count of the 24-bit field
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && i_s2.sum[i]) begin
                found = 1'b1;
                lz    = 5'(23 - i);
            end
        end
        sh   = 5'd0;
        m    = 24'd0;
        e    = 9'd0;
        o_s3 = '0;
        if (i_s2.special) begin
            o_s3.bits = i_s2.special_bits;
        end else if (i_s2.sum == 25'd0) begin
            o_s3.bits = 32'd0;
        end else if (i_s2.sum[24]) begin
            m = i_s2.sum[24:1];
            e = {1'b0, i_s2.big_e} + 9'd1;
            if (e >= 9'd255) begin
                o_s3.bits = {i_s2.sign, fpas_pkg::EXP_MAX, 23'd0};
                o_s3.ovf  = 1'b1;
            end else begin
                o_s3.bits = {i_s2.sign, e[7:0], m[22:0]};
            end
        end else begin
            // shift stops at biased exponent 1
            sh = ({3'd0, lz} < (i_s2.big_e - 8'd1)) ? lz : 5'(i_s2.big_e - 8'd1);
            m  = i_s2.sum[23:0] << sh;
            e  = {1'b0, i_s2.big_e} - {4'd0, sh};
            o_s3.bits = {i_s2.sign, m[23] ? e[7:0] : 8'd0, m[22:0]};
        end
    end
endmodule

// ===== src/fp32_add_sub_truncating.sv =====
// Top level: three-stage pipelined fp32 adder/subtractor with truncation.
// Path: each input passes the unpack, align/add and normalize registers in that order;
// o_valid and the result come from the normalize register.
// Throughput: one item per cycle unless stalled; each stage moves on when the next frees.
// Stall: a full pipeline holds in place while i_ready is low.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data regs are not reset.
module fp32_add_sub_truncating (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_result_bits,
    output logic        o_overflowed
);
    fpas_pkg::t_s1 n_s1, r_s1;
    fpas_pkg::t_s2 n_s2, r_s2;
    fpas_pkg::t_s3 n_s3, r_s3;
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    fpas_unpack    u_unpack (.i_sub(i_req_type), .i_a(i_operand_a), .i_b(i_operand_b),
                             .o_s1(n_s1));
    fpas_align_add u_add    (.i_s1(r_s1), .o_s2(n_s2));
    fpas_norm      u_norm   (.i_s2(r_s2), .o_s3(n_s3));

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
        if (adv1) r_s1 <= n_s1;
        if (adv2) r_s2 <= n_s2;
        if (adv3) r_s3 <= n_s3;
    end

    assign o_valid       = r_v3;
    assign o_result_bits = r_s3.bits;
    assign o_overflowed  = r_s3.ovf;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_bits))
        else $error("result changed under stall");
    a_ovf_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflowed |-> o_result_bits[30:0] == 31'h7F80_0000)
        else $error("overflow without infinity");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && adv3 |=> r_v3)
        else $error("item lost between stages");
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the truncating fp32 adder/subtractor: directed table plus random items.
`timescale 1ns / 100ps

module tb_top;

    localparam int N_RANDOM   = 880;
    localparam int WDOG_LIMIT = 2000;

    typedef struct {
        logic        sub;
        logic [31:0] a;
        logic [31:0] b;
        logic        known;   // expected value typed in
        logic [31:0] res;
        logic        ovf;
    } t_vec;

    typedef struct {
        logic [31:0] bits;
        logic        ovf;
    } t_sum;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_req_type;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_result_bits;
    logic        o_overflowed;

    fp32_add_sub_truncating uut (.*);

    t_sum sum_queue[$];
    int   n_errors;
    bit   feed_done;
    bit   calm;        // no idling near the end
    bit   hold_off;
    int   idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Truncating fp32 add, computed the same way the hardware is meant to.
    function automatic t_sum fp_add_trunc(logic sub, logic [31:0] a_in, logic [31:0] b_in);
        t_sum        r;
        logic [31:0] a, b, big, sml;
        logic [7:0]  ae, be;
        logic [31:0] big_e, sml_e, big_m, sml_m, shamt, m, e;
        logic        a_nan, b_nan, a_inf, b_inf, sgn;
        a = a_in;
        b = b_in ^ {sub, 31'd0};
        ae = a[30:23];
        be = b[30:23];
        a_nan = (ae == 8'hFF) && (a[22:0] != 0);
        b_nan = (be == 8'hFF) && (b[22:0] != 0);
        a_inf = (ae == 8'hFF) && (a[22:0] == 0);
        b_inf = (be == 8'hFF) && (b[22:0] == 0);
        r.ovf = 1'b0;
        if (a_nan || b_nan) r.bits = fpas_pkg::QUIET_NAN;
        else if (a_inf && b_inf) r.bits = (a[31] ^ b[31]) ? fpas_pkg::QUIET_NAN : a;
        else if (a_inf) r.bits = a;
        else if (b_inf) r.bits = b;
        else begin
            big = (a[30:0] >= b[30:0]) ? a : b;
            sml = (a[30:0] >= b[30:0]) ? b : a;
            sgn = big[31];
            big_e = {24'd0, big[30:23]};
            sml_e = {24'd0, sml[30:23]};
            big_m = {9'd0, big[22:0]};
            sml_m = {9'd0, sml[22:0]};
            if (big_e != 0) big_m[23] = 1'b1; else big_e = 1;
            if (sml_e != 0) sml_m[23] = 1'b1; else sml_e = 1;
            shamt = big_e - sml_e;
            sml_m = (shamt >= 25) ? 32'd0 : (sml_m >> shamt);
            m = (a[31] ^ b[31]) ? big_m - sml_m : big_m + sml_m;
            e = big_e;
            if (m == 0) r.bits = 32'd0;
            else begin
                if (m >= 32'h0100_0000) begin
                    m = m >> 1;
                    e = e + 1;
                end
                while (m < 32'h0080_0000 && e > 1) begin
                    m = m << 1;
                    e = e - 1;
                end
                if (e >= 255) begin
                    r.bits = {sgn, fpas_pkg::EXP_MAX, 23'd0};
                    r.ovf  = 1'b1;
                end else begin
                    r.bits = {sgn, (m < 32'h0080_0000) ? 8'd0 : e[7:0], m[22:0]};
                end
            end
        end
        return r;
    endfunction

    // Mostly finite values, often with exponents near each other, some specials.
    function automatic logic [31:0] rand_operand(logic [7:0] near_e);
        logic [31:0] v;
        int          pick;
        pick = $urandom_range(0, 99);
        v = $urandom;
        if (pick < 45)      v[30:23] = near_e + 8'($urandom_range(0, 6)) - 8'd3;
        else if (pick < 52) v[30:23] = 8'h00;
        else if (pick < 58) v[30:23] = 8'hFF;
        else if (pick < 62) v[30:0]  = 31'd0;
        else if (pick < 70) v[30:23] = 8'($urandom_range(250, 254));
        return v;
    endfunction

    task automatic send_item(logic sub, logic [31:0] a, logic [31:0] b);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= sub;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sum_queue.push_back(fp_add_trunc(sub, a, b));
        @(negedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_vec        dir[$];
        t_sum        p;
        logic [31:0] a, b;
        logic [7:0]  e;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
        feed_done   = 1'b0;
        calm        = 1'b0;
        dir = '{
            '{1'b0, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4000_0000, 1'b0},
            '{1'b1, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{1'b0, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{1'b0, 32'h7F80_0000, 32'h3F80_0000, 1'b1, 32'h7F80_0000, 1'b0},
            '{1'b1, 32'h7F80_0000, 32'h7F80_0000, 1'b1, 32'h7FC0_0000, 1'b0},
            '{1'b0, 32'h7F80_0000, 32'hFF80_0000, 1'b1, 32'h7FC0_0000, 1'b0},
            '{1'b0, 32'hFF80_0000, 32'hFF80_0000, 1'b1, 32'hFF80_0000, 1'b0},
            '{1'b1, 32'h0000_0000, 32'h7F80_0000, 1'b1, 32'hFF80_0000, 1'b0},
            '{1'b0, 32'h7FC0_0001, 32'h3F80_0000, 1'b1, 32'h7FC0_0000, 1'b0},
            '{1'b1, 32'h3F80_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FC0_0000, 1'b0},
            '{1'b0, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'h7F80_0000, 1'b1},
            '{1'b1, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 1'b1, 32'hFF80_0000, 1'b1},
            '{1'b0, 32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0002, 1'b0},
            '{1'b0, 32'h007F_FFFF, 32'h0000_0001, 1'b1, 32'h0080_0000, 1'b0},
            '{1'b1, 32'h0080_0000, 32'h0000_0001, 1'b1, 32'h007F_FFFF, 1'b0},
            '{1'b0, 32'h3F80_0000, 32'hBF80_0000, 1'b1, 32'h0000_0000, 1'b0},
            '{1'b1, 32'h3F80_0000, 32'h4000_0000, 1'b0, 32'h0, 1'b0},
            '{1'b0, 32'h4B80_0000, 32'h3F80_0001, 1'b0, 32'h0, 1'b0},
            '{1'b0, 32'h3F80_0000, 32'h3380_0000, 1'b0, 32'h0, 1'b0},
            '{1'b1, 32'h3F80_0000, 32'h3F7F_FFFF, 1'b0, 32'h0, 1'b0},
            '{1'b0, 32'h0000_0000, 32'hBF80_0000, 1'b0, 32'h0, 1'b0},
            '{1'b1, 32'hC2C8_0000, 32'h4249_0FDB, 1'b0, 32'h0, 1'b0}
        };
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (dir[k]) begin
            send_item(dir[k].sub, dir[k].a, dir[k].b);
            if (dir[k].known) begin
                p = sum_queue[$];
                if (p.bits !== dir[k].res || p.ovf !== dir[k].ovf)
                    $error("table row %0d: predictor gives %h/%0b, table %h/%0b",
                           k, p.bits, p.ovf, dir[k].res, dir[k].ovf);
                if (p.bits !== dir[k].res || p.ovf !== dir[k].ovf) n_errors++;
            end
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == N_RANDOM - 150) calm = 1'b1;
            e = 8'($urandom);
            a = rand_operand(e);
            b = rand_operand(e);
            send_item(1'($urandom_range(0, 1)), a, b);
        end
        i_valid   <= 1'b0;
        feed_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off early on
    initial begin
        int n;
        i_ready  = 1'b0;
        hold_off = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        repeat (60) begin
            i_ready <= 1'b1;
            @(negedge i_clk);
        end
        hold_off = 1'b1;
        i_ready <= 1'b0;
        repeat (40) @(negedge i_clk);
        hold_off = 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 13);
                i_ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Result check
    always @(posedge i_clk) begin
        t_sum x;
        if (i_rst_n && o_valid && i_ready) begin
            if (sum_queue.size() == 0) begin
                $error("result %h arrived with nothing expected", o_result_bits);
                n_errors++;
            end else begin
                x = sum_queue.pop_front();
                if (o_result_bits !== x.bits) begin
                    $error("result_bits: expected %h, actual %h", x.bits, o_result_bits);
                    n_errors++;
                end
                if (o_overflowed !== x.ovf) begin
                    $error("overflowed: expected %0b, actual %0b", x.ovf, o_overflowed);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog and end of run
    initial begin
        n_errors    = 0;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || hold_off) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
            if (feed_done && sum_queue.size() == 0) begin
                repeat (10) @(posedge i_clk);
                if (n_errors == 0 && !o_valid) begin
                    $display("SUCCESS");
                end else begin
                    if (o_valid) $error("unexpected result after the last one");
                    $display("FAILURE");
                end
                $finish;
            end
        end
    end

endmodule
